[design/ssmp_pkg.sv]
// Shared types, constants and the digit encoder for the seven-segment scan driver.
// No dependencies; every other design file imports this package.
package ssmp_pkg;

    localparam int DIGIT_COUNT      = 4;
    localparam int NUM_INPUT_DIGITS = 4;
    localparam int NUM_CFG_REGS     = 4;
    localparam int DIGIT_W          = 4;
    localparam int SEG_W            = 8;
    localparam int EN_W             = 4;
    localparam int BRIGHT_W         = 8;
    localparam int COUNT_W          = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int PHASE_W          = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    localparam logic [BRIGHT_W-1:0] COMPARE_RESET = 8'd100;
    localparam logic [SEG_W-1:0]    SEG_BLANK     = 8'h00;

    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS_0 = 2'd0,
        REG_BRIGHTNESS_1 = 2'd1,
        REG_BRIGHTNESS_2 = 2'd2,
        REG_BRIGHTNESS_3 = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        op_t                operation;
        logic [DIGIT_W-1:0] digit_0;
        logic [DIGIT_W-1:0] digit_1;
        logic [DIGIT_W-1:0] digit_2;
        logic [DIGIT_W-1:0] digit_3;
    } in_t;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [EN_W-1:0]  digit_enable;
    } out_t;

    typedef struct packed {
        logic                 we;
        cfg_idx_t             index;
        logic [BRIGHT_W-1:0]  data;
    } cfg_wr_t;

    // Decimal value to segment pattern; anything above nine is blank.
    function automatic logic [SEG_W-1:0] encode_digit(input logic [DIGIT_W-1:0] v);
        logic [SEG_W-1:0] code;
        code = SEG_BLANK;
        if (v <= DIGIT_W'(9)) begin
            code = SEG_TABLE[v];
        end
        return code;
    endfunction

endpackage

[design/ssmp_encode.sv]
// Turns the four decimal digits of a load beat into segment codes, one per slot.
// Depends on ssmp_pkg.
module ssmp_encode
    import ssmp_pkg::*;
(
    input  in_t                                 item,
    output logic [DIGIT_COUNT-1:0][SEG_W-1:0]   codes
);

    logic [DIGIT_W-1:0] digits [NUM_INPUT_DIGITS];

    assign digits[0] = item.digit_0;
    assign digits[1] = item.digit_1;
    assign digits[2] = item.digit_2;
    assign digits[3] = item.digit_3;

    // Slots past the input digits stay blank.
    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (i < NUM_INPUT_DIGITS) begin
                codes[i] = encode_digit(digits[i]);
            end else begin
                codes[i] = SEG_BLANK;
            end
        end
    end

endmodule

[design/ssmp_scan.sv]
// Scan state: tick counter, digit phase, compare value, output latches, stored
// codes and brightness registers. Depends on ssmp_pkg and ssmp_encode.
module ssmp_scan
    import ssmp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  in_t      item,
    input  cfg_wr_t  cfg,
    output out_t     result
);

    logic [COUNT_W-1:0]   tick_count_reg,    tick_count_next;
    logic [PHASE_W-1:0]   scan_phase_reg,    scan_phase_next;
    logic [BRIGHT_W-1:0]  compare_value_reg, compare_value_next;
    logic [SEG_W-1:0]     segment_latch_reg, segment_latch_next;
    logic [EN_W-1:0]      enable_latch_reg,  enable_latch_next;
    logic [DIGIT_COUNT-1:0][SEG_W-1:0]    seg_codes_reg;
    logic [DIGIT_COUNT-1:0][SEG_W-1:0]    load_codes;
    logic [DIGIT_COUNT-1:0][BRIGHT_W-1:0] brightness_reg;
    logic [EN_W-1:0]      phase_enable;
    logic                 wrap;

    ssmp_encode u_encode (
        .item  (item),
        .codes (load_codes)
    );

    // Position k drives enable bit DIGIT_COUNT-1-k; bits past the field drop.
    always_comb begin
        for (int b = 0; b < EN_W; b++) begin
            phase_enable[b] = (b < DIGIT_COUNT) &&
                              (int'(scan_phase_reg) == DIGIT_COUNT - 1 - b);
        end
    end

    always_comb begin
        tick_count_next    = tick_count_reg;
        scan_phase_next    = scan_phase_reg;
        compare_value_next = compare_value_reg;
        segment_latch_next = segment_latch_reg;
        enable_latch_next  = enable_latch_reg;
        wrap               = 1'b0;
        if (item.operation == OP_TICK) begin
            tick_count_next = tick_count_reg + 1'b1;
            wrap            = (tick_count_next == '0);
            if (wrap) begin
                // wrap wins over match
                segment_latch_next = seg_codes_reg[scan_phase_reg];
                enable_latch_next  = phase_enable;
                compare_value_next = brightness_reg[scan_phase_reg];
                if (scan_phase_reg == PHASE_W'(DIGIT_COUNT - 1)) begin
                    scan_phase_next = '0;
                end else begin
                    scan_phase_next = scan_phase_reg + 1'b1;
                end
            end else if (tick_count_next == compare_value_reg) begin
                enable_latch_next = '0;
            end
        end
    end

    assign result.segments     = segment_latch_next;
    assign result.digit_enable = enable_latch_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= '0;
            scan_phase_reg    <= '0;
            compare_value_reg <= COMPARE_RESET;
            segment_latch_reg <= '0;
            enable_latch_reg  <= '0;
            seg_codes_reg     <= '0;
        end else if (step) begin
            tick_count_reg    <= tick_count_next;
            scan_phase_reg    <= scan_phase_next;
            compare_value_reg <= compare_value_next;
            segment_latch_reg <= segment_latch_next;
            enable_latch_reg  <= enable_latch_next;
            if (item.operation == OP_LOAD) begin
                seg_codes_reg <= load_codes;
            end
        end
    end

    // Slots beyond the register list keep brightness 0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= '0;
        end else if (cfg.we) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                if (i < NUM_CFG_REGS && cfg.index == cfg_idx_t'(CFG_IDX_W'(i))) begin
                    brightness_reg[i] <= cfg.data;
                end
            end
        end
    end

    a_enable_onehot0: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(enable_latch_reg))
        else $error("more than one digit enabled");

    a_load_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.operation == OP_LOAD |=>
            $stable(tick_count_reg) && $stable(enable_latch_reg))
        else $error("load beat disturbed scan state");

    a_wrap_loads_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        step && wrap |=>
            compare_value_reg == $past(brightness_reg[scan_phase_reg]))
        else $error("compare value not taken from active digit brightness");

    a_seg_top_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        segment_latch_reg[SEG_W-1] == 1'b0)
        else $error("segment latch bit 7 set");

endmodule

[design/seven_segment_mux_pwm.sv]
// Top level of the multiplexed seven-segment driver with per-digit brightness.
// Depends on ssmp_pkg and ssmp_scan (which holds ssmp_encode).
//
//  channel | handshake            | payload            | direction
//  --------+----------------------+--------------------+----------
//  input   | s_valid / s_ready    | s_data   (in_t)    | in
//  result  | m_valid / m_ready    | m_data   (out_t)   | out
//  config  | cfg_valid / cfg_ready| cfg_index,cfg_data | in
//
// One beat per cycle sustained while m_ready is high: an input register, then
// one pass through the scan logic into the result register, which presents
// the result. The two register stages hold each beat in turn.
// Synchronous active-low reset clears counter, phase, latches, stored codes
// and brightness; compare value resets to 100. A stalled result register
// holds the input register; s_ready drops only when both stages are full
// and m_ready is low. cfg_ready is always high.
module seven_segment_mux_pwm
    import ssmp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BRIGHT_W-1:0]   cfg_data
);

    logic     in_valid_reg;
    in_t      in_data_reg;
    logic     out_valid_reg;
    out_t     out_data_reg;
    logic     step;
    out_t     result;
    cfg_wr_t  cfg;

    // A held beat moves on when the result register is empty or being drained.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    assign cfg_ready = 1'b1;
    assign cfg.we    = cfg_valid;
    assign cfg.index = cfg_idx_t'(cfg_index);
    assign cfg.data  = cfg_data;

    ssmp_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the seven_segment_mux_pwm display scan driver.
// Depends on ssmp_pkg (beat types, operation and register codes) and the RTL.
// Stimulus, a scan-state predictor and a result checker all live in tb.
module tb;
    import ssmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BRIGHT_W-1:0]  cfg_data;

    seven_segment_mux_pwm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Every input known from time zero.
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Scan-state predictor
    // Mirrors the driver: a free-running 8-bit tick counter, a 2-bit scan
    // slot, the on-time limit of the lit digit and the two output latches.
    // ------------------------------------------------------------------
    localparam logic [SEG_W-1:0] GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    logic [COUNT_W-1:0]  ticks        = '0;
    logic [PHASE_W-1:0]  scan_slot    = '0;
    logic [BRIGHT_W-1:0] on_limit     = COMPARE_RESET;
    logic [SEG_W-1:0]    seg_hold     = '0;
    logic [EN_W-1:0]     en_hold      = '0;
    logic [SEG_W-1:0]    glyph_store  [DIGIT_COUNT] = '{default: '0};
    logic [BRIGHT_W-1:0] bright_level [NUM_CFG_REGS] = '{default: '0};

    out_t expected_frames [$];
    int   mismatch_count = 0;

    function automatic logic [SEG_W-1:0] glyph_of(input logic [DIGIT_W-1:0] v);
        // Anything above nine is drawn blank.
        return (v <= 4'd9) ? GLYPH[v] : '0;
    endfunction

    function automatic void advance_display(input in_t item);
        out_t frame;
        if (item.operation == OP_LOAD) begin
            // A load only refreshes the stored glyphs; latches keep their values.
            glyph_store[0] = glyph_of(item.digit_0);
            glyph_store[1] = glyph_of(item.digit_1);
            glyph_store[2] = glyph_of(item.digit_2);
            glyph_store[3] = glyph_of(item.digit_3);
        end else begin
            ticks = ticks + 1'b1;
            if (ticks == '0) begin
                // Wrap: blank all, light the next slot, take its on-time.
                // Checked first, so an on-time of zero keeps the digit lit.
                seg_hold  = glyph_store[scan_slot];
                en_hold   = EN_W'(1) << (DIGIT_COUNT - 1 - scan_slot);
                on_limit  = bright_level[scan_slot];
                scan_slot = scan_slot + 1'b1;
            end else if (ticks == on_limit) begin
                en_hold = '0;
            end
        end
        frame.segments     = seg_hold;
        frame.digit_enable = en_hold;
        expected_frames.push_back(frame);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every accepted result beat against the oldest frame.
    // Sampled at the rising edge, before the DUT's own updates land.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : frame_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                flag_mismatch("result beat with nothing pending", int'(m_data), 0);
            end else begin
                want = expected_frames.pop_front();
                if (m_data.segments !== want.segments)
                    flag_mismatch("segments", int'(m_data.segments),
                                  int'(want.segments));
                if (m_data.digit_enable !== want.digit_enable)
                    flag_mismatch("digit_enable", int'(m_data.digit_enable),
                                  int'(want.digit_enable));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stall bursts, plus a long hold-off on request.
    // ------------------------------------------------------------------
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    int hold_off_req    = 0;

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req > 0) begin
                hold         = hold_off_req;
                hold_off_req = 0;
            end
            if (hold == 0 && receiver_stalls && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 5);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver side
    // ------------------------------------------------------------------

    // One input beat; a random gap burst may come first. Valid stays up
    // until the handshake, and the predictor runs on acceptance.
    task automatic send_beat(input in_t item);
        int gap;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        advance_display(item);
    endtask

    // Drop valid and wait until every predicted frame has come back.
    task automatic drain_display;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [BRIGHT_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        bright_level[idx] = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Brightness only changes with the pipe empty.
    task automatic set_brightness(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3);
        drain_display();
        write_register(REG_BRIGHTNESS_0, b0);
        write_register(REG_BRIGHTNESS_1, b1);
        write_register(REG_BRIGHTNESS_2, b2);
        write_register(REG_BRIGHTNESS_3, b3);
    endtask

    function automatic in_t make_beat(input op_t op, input logic [3:0] d0,
                                      input logic [3:0] d1, input logic [3:0] d2,
                                      input logic [3:0] d3);
        in_t item;
        item.operation = op;
        item.digit_0   = d0;
        item.digit_1   = d1;
        item.digit_2   = d2;
        item.digit_3   = d3;
        return item;
    endfunction

    // Mostly decimal digits, a quarter out of range (blank).
    function automatic logic [3:0] rand_digit;
        if ($urandom_range(0, 3) == 0)
            return 4'($urandom_range(10, 15));
        return 4'($urandom_range(0, 9));
    endfunction

    // Ticks dominate so the counter keeps wrapping through every slot;
    // loads are sprinkled in to swap glyphs mid-scan.
    function automatic in_t rand_beat(input int load_pct);
        op_t op;
        op = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_TICK;
        return make_beat(op, rand_digit(), rand_digit(), rand_digit(), rand_digit());
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every glyph, every blank code, all-zero and all-one digit fields,
    // and ticks with junk digits.
    task automatic test_digit_encoding;
        set_brightness(8'd0, 8'd255, 8'd1, 8'd128);
        send_beat(make_beat(OP_TICK, 4'hF, 4'hF, 4'hF, 4'hF));
        send_beat(make_beat(OP_LOAD, 4'd0, 4'd1, 4'd2, 4'd3));
        send_beat(make_beat(OP_TICK, 4'h0, 4'h0, 4'h0, 4'h0));
        send_beat(make_beat(OP_LOAD, 4'd4, 4'd5, 4'd6, 4'd7));
        send_beat(make_beat(OP_LOAD, 4'd8, 4'd9, 4'd10, 4'd11));
        send_beat(make_beat(OP_TICK, 4'hA, 4'h5, 4'hA, 4'h5));
        send_beat(make_beat(OP_LOAD, 4'd12, 4'd13, 4'd14, 4'd15));
        send_beat(make_beat(OP_LOAD, 4'hF, 4'hF, 4'hF, 4'hF));
        send_beat(make_beat(OP_LOAD, 4'h0, 4'h0, 4'h0, 4'h0));
        send_beat(make_beat(OP_LOAD, 4'd9, 4'd8, 4'd7, 4'd6));
        send_beat(make_beat(OP_TICK, 4'h5, 4'hA, 4'h5, 4'hA));
    endtask

    task automatic test_random_traffic(input int count, input int load_pct);
        repeat (count) send_beat(rand_beat(load_pct));
    endtask

    // Sink holds off for a long stretch while beats keep coming, so the
    // pipe fills and s_ready has to drop.
    task automatic test_back_pressure;
        hold_off_req = 60;
        repeat (30) send_beat(rand_beat(10));
    endtask

    // Full-rate stream with no gaps or stalls on either side.
    task automatic test_steady_stream(input int count);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        repeat (count) send_beat(rand_beat(8));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_digit_encoding();
        test_random_traffic(400, 10);

        set_brightness(8'd255, 8'd0, 8'd254, 8'd1);
        test_random_traffic(300, 10);
        test_back_pressure();

        set_brightness(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        test_random_traffic(420, 12);

        set_brightness(8'd1, 8'd128, 8'd0, 8'd255);
        test_steady_stream(400);

        // Let any straggler beat show up before the verdict.
        drain_display();
        repeat (6) @(posedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
